// ===== sv/opfs_pkg.sv =====
`default_nettype none
package opfs_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;

  localparam int INIT_LEN = 25;
  localparam int INIT_W   = 5;

  // APB: one 32-bit register at byte address 0
  localparam int APB_AW = 3;
  localparam logic [0:0] REG_DEVICE_ADDRESS = 1'b0;
  localparam logic [7:0] DEV_ADDR_RST = 8'd120;

  localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
  localparam logic [7:0] CMD_COL_LOW   = 8'h00;
  localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

  typedef enum logic [2:0] {
    ACT_DRAW    = 3'd0,
    ACT_TICK    = 3'd1,
    ACT_REFRESH = 3'd2,
    ACT_CLEAR   = 3'd3,
    ACT_INIT    = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_INIT,
    MODE_CLEAR,
    MODE_REFRESH
  } mode_e;

  typedef enum logic [1:0] {
    ST_READY,
    ST_DRAW,
    ST_TICK
  } state_e;

  typedef struct packed {
    logic draw_rd;      // accepted in-range draw: latch pixel, read word
    logic draw_wr;      // write back the modified word
    logic tick_scan;    // page scan transaction: advance counters, read word
    logic tick_init;    // init command transaction
    logic scan_begin;   // page and step back to zero
    logic store_clear;  // drop every word of the store
    logic init_begin;
    logic emit;         // result on the ports this cycle
  } dp_cmd_t;

  typedef struct packed {
    logic in_range;
    logic init_last;
    logic scan_last;
  } dp_stat_t;

  function automatic logic [7:0] init_cmd(input logic [INIT_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      5'd0:    c = 8'hAE;
      5'd1:    c = 8'hD5;
      5'd2:    c = 8'h80;
      5'd3:    c = 8'hA8;
      5'd4:    c = 8'h3F;
      5'd5:    c = 8'hD3;
      5'd6:    c = 8'h00;
      5'd7:    c = 8'h40;
      5'd8:    c = 8'h8D;
      5'd9:    c = 8'h14;
      5'd10:   c = 8'h20;
      5'd11:   c = 8'h00;
      5'd12:   c = 8'hA1;
      5'd13:   c = 8'hC8;
      5'd14:   c = 8'hDA;
      5'd15:   c = 8'h12;
      5'd16:   c = 8'h81;
      5'd17:   c = 8'hCF;
      5'd18:   c = 8'hD9;
      5'd19:   c = 8'hF1;
      5'd20:   c = 8'hDB;
      5'd21:   c = 8'h40;
      5'd22:   c = 8'hA4;
      5'd23:   c = 8'hA6;
      5'd24:   c = 8'hAF;
      default: c = 8'hAE;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== sv/oled_page_framebuffer_sequencer.sv =====
`default_nettype none
// Page-organized monochrome frame store (COLUMNS x PAGES bytes) with a display
// write sequencer.
// Input channel: an item (action, pixel fields) is taken at a clock edge with
// start high and busy low. Draw items update one pixel; start actions arm an
// init, clear or refresh sequence; each tick item of a running sequence makes
// one bus write transaction.
// Result channel: strobe_o marks one cycle carrying address_byte, is_data,
// payload_byte and sequence_done. The receiver cannot stall; every result is
// taken in the cycle it is shown.
// Timing: a tick that produces a result shows it in the cycle after it was
// taken (the store read is registered). Ticks of a running sequence and
// in-range draws then raise busy (draw: read then write back the store word),
// so the next item waits for busy to drop; all other items leave busy low.
// Reset: sequencer idle, counters zero, device address 120. The store reads as
// all zero after reset and after each clear through per-word valid flops, so
// there is no clearing pass.
// Config: APB register 0 (byte address 0) holds the device address; write it
// only while no sequence runs.
module oled_page_framebuffer_sequencer #(
  parameter int COLUMNS = opfs_pkg::COLUMNS_DEF,
  parameter int PAGES   = opfs_pkg::PAGES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [2:0]                  action_i,
  input  wire logic [7:0]                  pixel_x_i,
  input  wire logic [7:0]                  pixel_y_i,
  input  wire logic                        pixel_on_i,
  output logic                             strobe_o,
  output logic      [7:0]                  address_byte_o,
  output logic                             is_data_o,
  output logic      [7:0]                  payload_byte_o,
  output logic                             sequence_done_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [opfs_pkg::APB_AW-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  import opfs_pkg::*;

  dp_cmd_t    cmd;
  dp_stat_t   stat;
  logic       reg_hit;
  logic       cfg_we;
  logic [7:0] dev_addr;

  assign reg_hit = (paddr[APB_AW-1:2] == REG_DEVICE_ADDRESS);
  assign cfg_we  = psel && penable && pwrite && reg_hit;
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {24'd0, dev_addr} : 32'd0;

  opfs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .action_i(action_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy    (busy)
  );

  opfs_datapath #(
    .COLUMNS(COLUMNS),
    .PAGES  (PAGES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .pixel_x_i      (pixel_x_i),
    .pixel_y_i      (pixel_y_i),
    .pixel_on_i     (pixel_on_i),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata[7:0]),
    .dev_addr_o     (dev_addr),
    .is_data_o      (is_data_o),
    .payload_byte_o (payload_byte_o),
    .sequence_done_o(sequence_done_o)
  );

  assign strobe_o       = cmd.emit;
  assign address_byte_o = dev_addr;

  // every result follows an item taken in the previous cycle
  a_strobe_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> $past(start && !busy))
    else $error("result without a preceding item");

  // a sequence always ends on a data byte
  a_done_on_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && sequence_done_o) |-> is_data_o)
    else $error("sequence ended on a command");

  // busy is always low again in the cycle after it is high
  a_busy_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("busy held for two cycles");

  // a store write-back never coincides with a result
  a_no_wr_and_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.draw_wr && cmd.emit))
    else $error("write-back and result in the same cycle");

endmodule
`default_nettype wire

// ===== sv/opfs_ram.sv =====
`default_nettype none
module opfs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== sv/opfs_ctrl.sv =====
`default_nettype none
module opfs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  input  wire logic [2:0]        action_i,
  input  wire opfs_pkg::dp_stat_t stat_i,
  output opfs_pkg::dp_cmd_t      cmd_o,
  output logic                   busy
);

  import opfs_pkg::*;

  state_e state_q, state_d;
  mode_e  mode_q, mode_d;
  logic   accept;

  assign accept = start && (state_q == ST_READY);
  assign busy   = (state_q != ST_READY);

  // command decode
  always_comb begin
    cmd_o      = '0;
    cmd_o.emit = (state_q == ST_TICK);
    cmd_o.draw_wr = (state_q == ST_DRAW);
    if (accept) begin
      case (action_e'(action_i))
        ACT_DRAW: begin
          cmd_o.draw_rd = stat_i.in_range;
        end
        ACT_TICK: begin
          cmd_o.tick_init = (mode_q == MODE_INIT);
          cmd_o.tick_scan = (mode_q == MODE_CLEAR) || (mode_q == MODE_REFRESH);
          // last init command hands over to a clear
          cmd_o.scan_begin  = (mode_q == MODE_INIT) && stat_i.init_last;
          cmd_o.store_clear = (mode_q == MODE_INIT) && stat_i.init_last;
        end
        ACT_REFRESH: begin
          cmd_o.scan_begin = (mode_q == MODE_IDLE);
        end
        ACT_CLEAR: begin
          cmd_o.scan_begin  = (mode_q == MODE_IDLE);
          cmd_o.store_clear = (mode_q == MODE_IDLE);
        end
        ACT_INIT: begin
          cmd_o.init_begin = (mode_q == MODE_IDLE);
        end
        default: begin
          cmd_o.emit = 1'b0;
        end
      endcase
    end
  end

  // next state and sequence mode
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    case (state_q)
      ST_READY: begin
        if (cmd_o.draw_rd) begin
          state_d = ST_DRAW;
        end else if (cmd_o.tick_init || cmd_o.tick_scan) begin
          state_d = ST_TICK;
        end
      end
      ST_DRAW: state_d = ST_READY;
      ST_TICK: state_d = ST_READY;
      default: state_d = ST_READY;
    endcase

    if (accept && mode_q == MODE_IDLE) begin
      case (action_e'(action_i))
        ACT_REFRESH: mode_d = MODE_REFRESH;
        ACT_CLEAR:   mode_d = MODE_CLEAR;
        ACT_INIT:    mode_d = MODE_INIT;
        default:     mode_d = MODE_IDLE;
      endcase
    end else if (cmd_o.tick_init && stat_i.init_last) begin
      mode_d = MODE_CLEAR;
    end else if (cmd_o.tick_scan && stat_i.scan_last) begin
      mode_d = MODE_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_READY;
      mode_q  <= MODE_IDLE;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/opfs_datapath.sv =====
`default_nettype none
module opfs_datapath #(
  parameter int COLUMNS = opfs_pkg::COLUMNS_DEF,
  parameter int PAGES   = opfs_pkg::PAGES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire opfs_pkg::dp_cmd_t  cmd_i,
  output opfs_pkg::dp_stat_t      stat_o,
  input  wire logic [7:0]         pixel_x_i,
  input  wire logic [7:0]         pixel_y_i,
  input  wire logic               pixel_on_i,
  input  wire logic               cfg_we_i,
  input  wire logic [7:0]         cfg_wdata_i,
  output logic      [7:0]         dev_addr_o,
  output logic                    is_data_o,
  output logic      [7:0]         payload_byte_o,
  output logic                    sequence_done_o
);

  import opfs_pkg::*;

  // store word = 8 consecutive columns of one page
  localparam int WPP    = (COLUMNS + 7) / 8;
  localparam int DEPTH  = PAGES * WPP;
  localparam int AW     = $clog2(DEPTH);
  localparam int WORD_W = 64;
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int STEP_W = $clog2(COLUMNS + 3);

  logic [7:0]        dev_q;
  logic [PAGE_W-1:0] page_q;
  logic [STEP_W-1:0] step_q;
  logic [INIT_W-1:0] init_q;
  logic [DEPTH-1:0]  vld_q;
  logic              vrd_q;
  logic [AW-1:0]     wa_q;
  logic [2:0]        bsel_q;
  logic [2:0]        bit_q;
  logic              on_q;
  logic              is_data_q;
  logic [7:0]        cmd_byte_q;
  logic              done_q;

  logic              step_last, page_last, init_last;
  logic [STEP_W-1:0] col;
  logic [AW-1:0]     draw_addr, scan_addr, rd_addr;
  logic              rd_en;
  logic [7:0]        scan_cmd;
  logic [WORD_W-1:0] rdata, word_rd, word_wr;

  assign step_last = (step_q == STEP_W'(COLUMNS + 2));
  assign page_last = (page_q == PAGE_W'(PAGES - 1));
  assign init_last = (init_q == INIT_W'(INIT_LEN - 1));

  assign stat_o.in_range  = ({1'b0, pixel_x_i} < 9'(COLUMNS)) &&
                            ({1'b0, pixel_y_i} < 9'(PAGES * 8));
  assign stat_o.init_last = init_last;
  assign stat_o.scan_last = step_last && page_last;

  assign col       = step_q - STEP_W'(3);
  assign draw_addr = AW'(32'(pixel_y_i[7:3]) * WPP + 32'(pixel_x_i[7:3]));
  assign scan_addr = AW'(32'(page_q) * WPP + 32'(col >> 3));
  assign rd_en     = cmd_i.draw_rd || cmd_i.tick_scan;
  assign rd_addr   = cmd_i.draw_rd ? draw_addr : scan_addr;

  always_comb begin
    if (step_q == STEP_W'(0)) begin
      scan_cmd = CMD_PAGE_BASE + 8'(page_q);
    end else if (step_q == STEP_W'(1)) begin
      scan_cmd = CMD_COL_LOW;
    end else begin
      scan_cmd = CMD_COL_HIGH;
    end
  end

  // a word never written since the last clear reads as zero
  assign word_rd = vrd_q ? rdata : '0;

  always_comb begin
    word_wr = word_rd;
    word_wr[{bsel_q, bit_q}] = on_q;
  end

  opfs_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.draw_wr),
    .waddr_i(wa_q),
    .wdata_i(word_wr),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q  <= DEV_ADDR_RST;
      page_q <= '0;
      step_q <= '0;
      init_q <= '0;
      vld_q  <= '0;
      vrd_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        dev_q <= cfg_wdata_i;
      end
      if (cmd_i.scan_begin) begin
        page_q <= '0;
        step_q <= '0;
      end else if (cmd_i.tick_scan) begin
        step_q <= step_last ? '0 : step_q + STEP_W'(1);
        if (step_last) begin
          page_q <= page_last ? '0 : page_q + PAGE_W'(1);
        end
      end
      if (cmd_i.init_begin) begin
        init_q <= '0;
      end else if (cmd_i.tick_init) begin
        init_q <= init_last ? '0 : init_q + INIT_W'(1);
      end
      if (cmd_i.store_clear) begin
        vld_q <= '0;
      end else if (cmd_i.draw_wr) begin
        vld_q[wa_q] <= 1'b1;
      end
      if (rd_en) begin
        vrd_q <= vld_q[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      wa_q <= rd_addr;
    end
    if (cmd_i.draw_rd) begin
      bsel_q <= pixel_x_i[2:0];
      bit_q  <= pixel_y_i[2:0];
      on_q   <= pixel_on_i;
    end else if (cmd_i.tick_scan) begin
      bsel_q <= col[2:0];
    end
    if (cmd_i.tick_scan) begin
      is_data_q  <= (step_q >= STEP_W'(3));
      cmd_byte_q <= scan_cmd;
      done_q     <= step_last && page_last;
    end else if (cmd_i.tick_init) begin
      is_data_q  <= 1'b0;
      cmd_byte_q <= init_cmd(init_q);
      done_q     <= 1'b0;
    end
  end

  assign dev_addr_o      = dev_q;
  assign is_data_o       = is_data_q;
  assign payload_byte_o  = is_data_q ? word_rd[8*bsel_q +: 8] : cmd_byte_q;
  assign sequence_done_o = done_q;

endmodule
`default_nettype wire

// ===== verif/oled_page_framebuffer_sequencer_test.sv =====
`timescale 1ns / 1ps
module oled_page_framebuffer_sequencer_test;
  import opfs_pkg::*;

  localparam int COLS          = COLUMNS_DEF;
  localparam int PAGES_N       = PAGES_DEF;
  localparam int ROWS_N        = PAGES_N * 8;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS   = 30;
  localparam int PHASES        = 5;

  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  localparam logic [APB_AW-1:0] DEV_ADDR_REG    = {REG_DEVICE_ADDRESS, 2'b00};
  localparam logic [APB_AW-1:0] UNUSED_REG_ADDR = DEV_ADDR_REG + 3'd4;

  localparam logic [7:0] CMD_DISPLAY_OFF = 8'hAE;
  localparam logic [7:0] INIT_SEQ [INIT_LEN] = '{
    CMD_DISPLAY_OFF, 8'hD5, 8'h80, 8'hA8, 8'h3F, 8'hD3, 8'h00, 8'h40, 8'h8D,
    8'h14, 8'h20, 8'h00, 8'hA1, 8'hC8, 8'hDA, 8'h12, 8'h81, 8'hCF, 8'hD9,
    8'hF1, 8'hDB, 8'h40, 8'hA4, 8'hA6, 8'hAF
  };

  typedef struct packed {
    logic [7:0] addr;
    logic       is_data;
    logic [7:0] payload;
    logic       done;
  } txn_t;

  localparam txn_t NO_TXN = '0;

  typedef struct packed {
    logic [2:0] act;
    logic [7:0] px;
    logic [7:0] py;
    logic       pon;
    logic       typed;
    txn_t       want;
    logic       run_out;
  } row_t;

  localparam row_t DIR_ROWS [24] = '{
    '{ACT_TICK,      8'd0,   8'd0,   1'b1, 1'b0, NO_TXN, 1'b0}, // nothing running
    '{ACT_UNUSED_LO, 8'd255, 8'd255, 1'b1, 1'b0, NO_TXN, 1'b0},
    '{ACT_UNUSED_HI, 8'd0,   8'd0,   1'b0, 1'b0, NO_TXN, 1'b0},
    '{ACT_INIT,      8'd0,   8'd0,   1'b0, 1'b0, NO_TXN, 1'b0},
    '{ACT_REFRESH,   8'd0,   8'd0,   1'b0, 1'b0, NO_TXN, 1'b0}, // dropped, init running
    '{ACT_CLEAR,     8'd0,   8'd0,   1'b0, 1'b0, NO_TXN, 1'b0}, // dropped, init running
    '{ACT_TICK,      8'd0,   8'd0,   1'b0, 1'b1,
      '{DEV_ADDR_RST, 1'b0, CMD_DISPLAY_OFF, 1'b0}, 1'b0},
    '{ACT_DRAW,      8'd64,  8'd32,  1'b1, 1'b0, NO_TXN, 1'b1}, // wiped by init's clear
    '{ACT_TICK,      8'd0,   8'd0,   1'b0, 1'b0, NO_TXN, 1'b0}, // idle again
    '{ACT_DRAW,      8'd0,   8'd0,   1'b1, 1'b0, NO_TXN, 1'b0},
    '{ACT_DRAW,      8'd127, 8'd63,  1'b1, 1'b0, NO_TXN, 1'b0},
    '{ACT_DRAW,      8'd127, 8'd63,  1'b0, 1'b0, NO_TXN, 1'b0},
    '{ACT_DRAW,      8'd127, 8'd63,  1'b1, 1'b0, NO_TXN, 1'b0},
    '{ACT_DRAW,      8'd128, 8'd0,   1'b1, 1'b0, NO_TXN, 1'b0}, // off the right edge
    '{ACT_DRAW,      8'd0,   8'd64,  1'b1, 1'b0, NO_TXN, 1'b0}, // below the last page
    '{ACT_DRAW,      8'd255, 8'd255, 1'b1, 1'b0, NO_TXN, 1'b0},
    '{ACT_REFRESH,   8'd0,   8'd0,   1'b0, 1'b0, NO_TXN, 1'b0},
    '{ACT_CLEAR,     8'd0,   8'd0,   1'b0, 1'b0, NO_TXN, 1'b0}, // dropped, refresh running
    '{ACT_TICK,      8'd0,   8'd0,   1'b0, 1'b1,
      '{DEV_ADDR_RST, 1'b0, CMD_PAGE_BASE, 1'b0}, 1'b0},
    '{ACT_TICK,      8'd0,   8'd0,   1'b0, 1'b1,
      '{DEV_ADDR_RST, 1'b0, CMD_COL_LOW, 1'b0}, 1'b0},
    '{ACT_TICK,      8'd0,   8'd0,   1'b0, 1'b1,
      '{DEV_ADDR_RST, 1'b0, CMD_COL_HIGH, 1'b0}, 1'b0},
    '{ACT_TICK,      8'd0,   8'd0,   1'b0, 1'b0, NO_TXN, 1'b0}, // column 0 of page 0
    '{ACT_DRAW,      8'd1,   8'd0,   1'b1, 1'b0, NO_TXN, 1'b0}, // byte not yet sent
    '{ACT_TICK,      8'd0,   8'd0,   1'b0, 1'b0, NO_TXN, 1'b0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  action_i;
  logic [7:0]  pixel_x_i;
  logic [7:0]  pixel_y_i;
  logic        pixel_on_i;
  logic        strobe_o;
  logic [7:0]  address_byte_o;
  logic        is_data_o;
  logic [7:0]  payload_byte_o;
  logic        sequence_done_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [APB_AW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  oled_page_framebuffer_sequencer u_top (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow of the block: frame store, sequencer and register
  logic [7:0] frame_mem [COLS*PAGES_N];
  mode_e      scan_mode;
  int         page_q;
  int         step_q;
  int         init_q;
  logic [7:0] dev_addr;

  txn_t txn_q [$];
  logic typed_flag;
  txn_t typed_txn;

  int errors     = 0;
  int item_cnt   = 0;
  int useful_cnt = 0;
  int result_cnt = 0;
  int done_cnt   = 0;
  int cycle_cnt  = 0;
  int burst_left = 0;
  int gap_max    = 0;

  function automatic void wipe_store();
    foreach (frame_mem[i]) frame_mem[i] = 8'h00;
  endfunction

  function automatic void arm_scan(mode_e m);
    scan_mode = m;
    page_q    = 0;
    step_q    = 0;
  endfunction

  // Returns 1 when the item changes anything; has_txn marks a bus transaction.
  function automatic logic predict_item(input logic [2:0] act, input logic [7:0] px,
                                        input logic [7:0] py, input logic pon,
                                        output logic has_txn, output txn_t txn);
    int         idx;
    logic [7:0] mask;
    logic       hit;
    has_txn = 1'b0;
    txn     = NO_TXN;
    hit     = 1'b0;
    case (act)
      ACT_DRAW: begin
        if (px < COLS && py < ROWS_N) begin
          idx  = int'(py >> 3) * COLS + int'(px);
          mask = 8'd1 << py[2:0];
          frame_mem[idx] = pon ? (frame_mem[idx] | mask) : (frame_mem[idx] & ~mask);
          hit = 1'b1;
        end
      end
      ACT_REFRESH, ACT_CLEAR, ACT_INIT: begin
        if (scan_mode == MODE_IDLE) begin
          hit = 1'b1;
          if (act == ACT_REFRESH) begin
            arm_scan(MODE_REFRESH);
          end else if (act == ACT_CLEAR) begin
            wipe_store();
            arm_scan(MODE_CLEAR);
          end else begin
            scan_mode = MODE_INIT;
            init_q    = 0;
          end
        end
      end
      ACT_TICK: begin
        if (scan_mode != MODE_IDLE) begin
          hit      = 1'b1;
          has_txn  = 1'b1;
          txn.addr = dev_addr;
          if (scan_mode == MODE_INIT) begin
            txn.payload = INIT_SEQ[init_q];
            init_q++;
            if (init_q == INIT_LEN) begin
              init_q = 0;
              wipe_store();
              arm_scan(MODE_CLEAR);
            end
          end else begin
            if (step_q == 0) begin
              txn.payload = CMD_PAGE_BASE + 8'(page_q);
            end else if (step_q == 1) begin
              txn.payload = CMD_COL_LOW;
            end else if (step_q == 2) begin
              txn.payload = CMD_COL_HIGH;
            end else begin
              txn.is_data = 1'b1;
              txn.payload = frame_mem[page_q * COLS + step_q - 3];
            end
            step_q++;
            if (step_q == COLS + 3) begin
              step_q = 0;
              page_q++;
              if (page_q == PAGES_N) begin
                page_q    = 0;
                scan_mode = MODE_IDLE;
                txn.done  = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    return hit;
  endfunction

  task automatic report_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : monitor
    txn_t got;
    txn_t want;
    txn_t calc;
    logic has;
    logic eff;
    if (rst_ni) begin
      if (strobe_o) begin
        got.addr    = address_byte_o;
        got.is_data = is_data_o;
        got.payload = payload_byte_o;
        got.done    = sequence_done_o;
        if (txn_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, got %0h", $time, got);
        end else begin
          want = txn_q.pop_front();
          report_field("address_byte", want.addr, got.addr);
          report_field("is_data", 8'(want.is_data), 8'(got.is_data));
          report_field("payload_byte", want.payload, got.payload);
          report_field("sequence_done", 8'(want.done), 8'(got.done));
          result_cnt++;
          if (want.done) done_cnt++;
        end
      end
      if (start && !busy) begin
        item_cnt++;
        eff = predict_item(action_i, pixel_x_i, pixel_y_i, pixel_on_i, has, calc);
        if (eff) useful_cnt++;
        if (has) txn_q.push_back(typed_flag ? typed_txn : calc);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("oled_page_framebuffer_sequencer_test: done, errors");
      $finish;
    end
  end

  // sender bursts: random length, random gap in front of each burst
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = (gap_max == 0) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        start = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  // called and returns at a falling edge; start stays high for back-to-back items
  task automatic drive_item(input logic [2:0] act, input logic [7:0] px,
                            input logic [7:0] py, input logic pon,
                            input logic typed, input txn_t want);
    pace();
    start      = 1'b1;
    action_i   = act;
    pixel_x_i  = px;
    pixel_y_i  = py;
    pixel_on_i = pon;
    typed_flag = typed;
    typed_txn  = want;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  task automatic pick_item(output logic [2:0] act, output logic [7:0] px,
                           output logic [7:0] py, output logic pon);
    int r;
    r   = $urandom_range(0, 99);
    px  = 8'($urandom);
    py  = 8'($urandom);
    pon = 1'($urandom);
    if (scan_mode == MODE_IDLE && r < 60) begin
      act = 3'($urandom_range(ACT_REFRESH, ACT_INIT));
    end else if (r < 55) begin
      act = ACT_TICK;
    end else if (r < 85) begin
      act = ACT_DRAW;
      if ($urandom_range(0, 9) != 0) begin
        px = 8'($urandom_range(0, COLS - 1));
        py = 8'($urandom_range(0, ROWS_N - 1));
      end
    end else if (r < 93) begin
      act = 3'($urandom_range(ACT_REFRESH, ACT_INIT));
    end else begin
      act = 3'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
    end
  endtask

  // tick the running sequence to its end, with the odd draw mixed in
  task automatic run_out();
    while (scan_mode != MODE_IDLE) begin
      if ($urandom_range(0, 15) == 0)
        drive_item(ACT_DRAW, 8'($urandom_range(0, COLS - 1)),
                   8'($urandom_range(0, ROWS_N - 1)), 1'($urandom), 1'b0, NO_TXN);
      else
        drive_item(ACT_TICK, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, NO_TXN);
    end
  endtask

  task automatic settle();
    start = 1'b0;
    while (txn_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_xfer(input logic wr, input logic [APB_AW-1:0] addr,
                          input logic [31:0] wdata, output logic [31:0] rdata);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_device_address();
    logic [31:0] rd;
    apb_xfer(1'b0, DEV_ADDR_REG, 32'd0, rd);
    report_field("device_address readback", dev_addr, rd[7:0]);
  endtask

  task automatic write_device_address(input logic [7:0] value);
    logic [31:0] rd;
    apb_xfer(1'b1, DEV_ADDR_REG, {24'd0, value}, rd);
    dev_addr = value;
    check_device_address();
  endtask

  initial begin : stimulus
    logic [2:0]  act;
    logic [7:0]  px;
    logic [7:0]  py;
    logic        pon;
    logic [31:0] rd;
    int          base;
    int          phase_gap [PHASES];
    logic [7:0]  phase_addr [PHASES];
    phase_gap  = '{3, 0, 8, 1, 5};
    phase_addr = '{8'h00, 8'hFF, 8'($urandom), 8'($urandom), DEV_ADDR_RST};
    rst_ni     = 1'b0;
    start      = 1'b0;
    action_i   = ACT_DRAW;
    pixel_x_i  = 8'd0;
    pixel_y_i  = 8'd0;
    pixel_on_i = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = 32'd0;
    typed_flag = 1'b0;
    typed_txn  = NO_TXN;
    wipe_store();
    arm_scan(MODE_IDLE);
    init_q   = 0;
    dev_addr = DEV_ADDR_RST;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    check_device_address();

    gap_max = 2;
    foreach (DIR_ROWS[i]) begin
      drive_item(DIR_ROWS[i].act, DIR_ROWS[i].px, DIR_ROWS[i].py, DIR_ROWS[i].pon,
                 DIR_ROWS[i].typed, DIR_ROWS[i].want);
      if (DIR_ROWS[i].run_out) run_out();
    end
    settle();

    // random phases carry on with whatever sequence the table left running
    for (int p = 0; p < PHASES; p++) begin
      write_device_address(phase_addr[p]);
      if (p == 1) begin
        // write to an address with no register behind it: must change nothing
        apb_xfer(1'b1, UNUSED_REG_ADDR, $urandom, rd);
        check_device_address();
      end
      gap_max    = phase_gap[p];
      burst_left = 0;
      base       = useful_cnt;
      while (useful_cnt - base < PHASE_ITEMS) begin
        pick_item(act, px, py, pon);
        drive_item(act, px, py, pon, 1'b0, NO_TXN);
      end
      settle();
    end

    $display("%0d items taken, %0d transactions checked, %0d sequences run to the end",
             item_cnt, result_cnt, done_cnt);
    $display("device address at reset, 0, 255 and random; draws at and past the edges,");
    $display("starts while busy, idle ticks, unused actions and an unused register");
    if (errors == 0) begin
      $display("oled_page_framebuffer_sequencer_test: done, clean");
    end else begin
      $display("oled_page_framebuffer_sequencer_test: done, errors");
    end
    $finish;
  end

endmodule
